### rtl/ratc_pkg.sv
// ----------------------------------------------------------------------------
// ratc_pkg
// Shared sizes, action codes and state type of the range add threshold counter.
// ----------------------------------------------------------------------------
package ratc_pkg;

	// item table size
	localparam int MAX_ITEMS  = 1024;
	localparam int DIFF_DEPTH = MAX_ITEMS + 1;
	localparam int VAL_AW     = $clog2(MAX_ITEMS);
	localparam int DIFF_AW    = $clog2(DIFF_DEPTH);

	// field widths
	localparam int ACT_W  = 2;
	localparam int ITEM_W = 11;
	localparam int VAL_W  = 31;
	localparam int AMT_W  = 31;
	localparam int SUM_W  = 64;
	localparam int CNT_W  = 11;

	// item_count after reset
	localparam logic [ITEM_W-1:0] ITEM_COUNT_RST = ITEM_W'(1024);

	// action codes
	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RANGE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
	// unused code, accepted and dropped
	localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_UPD1  = 5'b00010,
		ST_UPD2  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

endpackage

### rtl/ratc_ram.sv
// ----------------------------------------------------------------------------
// ratc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ratc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/range_add_threshold_counter_top.sv
// ----------------------------------------------------------------------------
// range_add_threshold_counter_top
// Item value table with range reductions kept as a difference memory and a
// prefix-sum sweep that counts exhausted items.
// ----------------------------------------------------------------------------
// A load writes one item value. A range reduction does two read-modify-writes
// on the single write port of the difference memory (entry left-1 gains the
// amount, entry right loses it). A finish sweeps every entry of the difference
// memory, one per cycle, keeping the prefix sum and zeroing each entry behind
// it; out_valid rises when the sweep has drained, whatever item_count is, and
// the sweep leaves the difference memory clear for the next job. After reset
// the same sweep runs once without a result as a clearing pass; during it and
// during a finish in_stall is high. A finish is held off while an earlier
// count still waits on the output; loads and reductions are not. The user must
// write item_count through cfg_we/cfg_data only while the block is idle; the
// block itself does not enforce it.
module range_add_threshold_counter_top
	import ratc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [ITEM_W-1:0] cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ACT_W-1:0]  action,
	input  logic [ITEM_W-1:0] item_index,
	input  logic [VAL_W-1:0]  item_value,
	input  logic [ITEM_W-1:0] range_left,
	input  logic [ITEM_W-1:0] range_right,
	input  logic [AMT_W-1:0]  amount,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CNT_W-1:0]  exhausted_count
);

	state_t state_q;

	logic [ITEM_W-1:0] item_count_q;
	logic [ITEM_W-1:0] n_items;

	// latched reduction
	logic [DIFF_AW-1:0] left_q;
	logic [DIFF_AW-1:0] right_q;
	logic [SUM_W-1:0]   amt_q;

	// sweep pipeline
	logic               fin_q;
	logic [DIFF_AW-1:0] sweep_q;
	logic               valid_s1;
	logic               last_s1;
	logic               cnt_en_s1;
	logic [DIFF_AW-1:0] idx_s1;
	logic               valid_s2;
	logic               last_s2;
	logic               cnt_en_s2;
	logic [VAL_W-1:0]   val_s2;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   hit_q;
	logic [CNT_W-1:0]   hit_nxt;
	logic [SUM_W-1:0]   rem;

	// result register
	logic               out_valid_q;
	logic [CNT_W-1:0]   out_count_q;

	// memory ports
	logic               d_we;
	logic [DIFF_AW-1:0] d_waddr;
	logic [SUM_W-1:0]   d_wdata;
	logic [DIFF_AW-1:0] d_raddr;
	logic [SUM_W-1:0]   d_rdata;
	logic               v_we;
	logic [VAL_AW-1:0]  v_waddr;
	logic [VAL_W-1:0]   v_rdata;

	logic in_xfer;
	logic fin_start;
	logic load_ok;
	logic range_ok;

	// item count saturated at the table size
	assign n_items = (32'(item_count_q) > MAX_ITEMS) ? ITEM_W'(MAX_ITEMS) : item_count_q;

	// finish waits for the result register to be free
	assign in_stall = (state_q != ST_IDLE) || ((action == ACT_FINISH) && out_valid_q);
	assign in_xfer  = in_valid && !in_stall;

	// finish transfer starts a new sweep
	assign fin_start = (state_q == ST_IDLE) && in_xfer && (action == ACT_FINISH);

	assign load_ok  = (item_index != '0) && (32'(item_index) <= MAX_ITEMS);
	assign range_ok = (range_left != '0) && (range_left <= range_right)
		&& (range_right <= n_items);

	// value table: written by loads, read alongside the sweep
	assign v_we    = in_xfer && (action == ACT_LOAD) && load_ok;
	assign v_waddr = VAL_AW'(item_index - ITEM_W'(1));

	ratc_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ITEMS)
	) u_value_ram (
		.clk  (clk),
		.we   (v_we),
		.waddr(v_waddr),
		.wdata(item_value),
		.raddr(VAL_AW'(sweep_q)),
		.rdata(v_rdata)
	);

	// difference memory port steering
	always_comb begin
		d_we    = 1'b0;
		d_waddr = idx_s1;
		d_wdata = '0;
		d_raddr = sweep_q;
		unique case (state_q)
			ST_IDLE: begin
				// read entry left-1 during the reduction transfer
				d_raddr = DIFF_AW'(range_left - ITEM_W'(1));
			end
			ST_UPD1: begin
				d_we    = 1'b1;
				d_waddr = left_q;
				d_wdata = d_rdata + amt_q;
				d_raddr = right_q;
			end
			ST_UPD2: begin
				d_we    = 1'b1;
				d_waddr = right_q;
				d_wdata = d_rdata - amt_q;
			end
			ST_SWEEP, ST_DRAIN: begin
				// zero each entry in the cycle after it is read
				d_we    = valid_s1;
				d_waddr = idx_s1;
				d_wdata = '0;
			end
			default: begin
				d_we = 1'b0;
			end
		endcase
	end

	ratc_ram #(
		.WIDTH(SUM_W),
		.DEPTH(DIFF_DEPTH)
	) u_diff_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	// remainder against the prefix sum that already holds this entry
	assign rem     = SUM_W'(val_s2) - sum_q;
	assign hit_nxt = (valid_s2 && cnt_en_s2 && ((rem == '0) || rem[SUM_W-1]))
		? hit_q + CNT_W'(1) : hit_q;

	// control and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			fin_q        <= 1'b0;
			sweep_q      <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			sum_q        <= '0;
			hit_q        <= '0;
			out_valid_q  <= 1'b0;
			item_count_q <= ITEM_COUNT_RST;
		end else begin
			if (cfg_we) begin
				item_count_q <= cfg_data;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			valid_s1 <= (state_q == ST_SWEEP);
			valid_s2 <= valid_s1;
			// prefix sum and hit count restart with each finish
			if (fin_start) begin
				sum_q <= '0;
				hit_q <= '0;
			end else begin
				if (valid_s1) begin
					sum_q <= sum_q + d_rdata;
				end
				hit_q <= hit_nxt;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (action == ACT_RANGE) && range_ok) begin
						state_q <= ST_UPD1;
					end else if (in_xfer && (action == ACT_FINISH)) begin
						state_q <= ST_SWEEP;
						fin_q   <= 1'b1;
						sweep_q <= '0;
					end
				end
				ST_UPD1: begin
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + DIFF_AW'(1);
					if (32'(sweep_q) == DIFF_DEPTH - 1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s2 && last_s2) begin
						state_q <= ST_IDLE;
						if (fin_q) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_xfer) begin
			left_q  <= DIFF_AW'(range_left - ITEM_W'(1));
			right_q <= DIFF_AW'(range_right);
			amt_q   <= SUM_W'(amount);
		end
		idx_s1    <= sweep_q;
		last_s1   <= (32'(sweep_q) == DIFF_DEPTH - 1);
		cnt_en_s1 <= fin_q && (32'(sweep_q) < 32'(n_items));
		last_s2   <= last_s1;
		cnt_en_s2 <= cnt_en_s1;
		val_s2    <= v_rdata;
		if (valid_s2 && last_s2) begin
			out_count_q <= hit_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign exhausted_count = out_count_q;

	// checks

	// difference memory is only written by a reduction or the sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !d_we)
		else $error("difference memory written while idle");

	// a result appears only at the end of a finish sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2 && last_s2 && fin_q))
		else $error("result raised outside a finish sweep");

	// the last sweep entry leaves the pipeline only while draining
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |-> (state_q == ST_DRAIN))
		else $error("sweep pipeline out of step with state");

	// a finish never starts over a pending result
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && (sweep_q == '0) && fin_q |-> !out_valid_q)
		else $error("finish started while result pending");

endmodule
